>>> sv/two_class_priority_queue_defines.svh
// ----------------------------------------------------------------------------
// Two-class priority queue assertion macros
// Shared property forms for the checker; clock and reset are the top ports.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_PRIORITY_QUEUE_DEFINES_SVH
`define TWO_CLASS_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define TCPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define TCPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// Two-class priority queue package
// Command and status codes shared by the queue and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpq_pkg;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_cmd CMD_INSERT = 2'd0;
    localparam t_cmd CMD_SERVE  = 2'd1;
    localparam t_cmd CMD_LOOKUP = 2'd2;

    localparam t_status ST_DONE     = 3'd0;
    localparam t_status ST_DUP      = 3'd1;
    localparam t_status ST_EMPTY    = 3'd2;
    localparam t_status ST_FULL     = 3'd3;
    localparam t_status ST_NOTFOUND = 3'd4;

endpackage

`default_nettype wire

>>> sv/two_class_priority_queue.sv
// ----------------------------------------------------------------------------
// Two-class strict-priority queue of unique ids
// Preferred entries are served ahead of ordinary ones, FIFO within a class.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata (low bit up)                          tuser
//  -------   ---  ------------------------------------------  -------------
//  s (cmd)   in   id[ID_BITS], preferred, zero pad            cmd[2]
//  m (res)   out  served_id[ID_BITS], is_preferred,           status[3]
//                 occupancy[clog2(CAPACITY+1)], zero pad
//
//  Insert and lookup scan the entries held and stop early on a hit: the
//  single compare unit walks the shared entry memory one read per cycle,
//  preferred class first, behind a registered read.
//  Serve reads the head entry of the class it takes from; serve on an
//  empty queue and an unused command read nothing.
//  Reset clears the heads and counts; the entry memory keeps its contents
//  and is read only inside a class's count.
//  The input is not ready while an item is at work; a finished result waits
//  until the output register is free, and the next item is taken once it has moved there.
//
`default_nettype none

module two_class_priority_queue #(
    parameter int CAPACITY = 16,
    parameter int ID_BITS  = 16
) (
    input  wire logic                                                i_clk,
    input  wire logic                                                i_rst_n,
    // s tdata: id, preferred, zero pad
    input  wire logic [((ID_BITS+1+7)/8)*8-1:0]                      i_s_tdata,
    // s tuser: cmd
    input  wire tcpq_pkg::t_cmd                                      i_s_tuser,
    input  wire logic                                                i_s_tvalid,
    output logic                                                     o_s_tready,
    // m tdata: served_id, is_preferred, occupancy, zero pad
    output logic [((ID_BITS+1+$clog2(CAPACITY+1)+7)/8)*8-1:0]        o_m_tdata,
    // m tuser: status
    output tcpq_pkg::t_status                                        o_m_tuser,
    output logic                                                     o_m_tvalid,
    input  wire logic                                                i_m_tready
);
    import tcpq_pkg::*;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY+1);
    localparam int ADDR_W = IDX_W + 1;
    localparam int OUT_W  = ((ID_BITS+1+CNT_W+7)/8)*8;
    localparam int PAD_W  = OUT_W - (ID_BITS+1+CNT_W);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_RESOLVE = 3'd2;
    localparam logic [2:0] S_FETCH   = 3'd3;
    localparam logic [2:0] S_TAKE    = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    // Add two ring indexes (sum below twice the capacity) and wrap.
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (IDX_W+1)'(CAPACITY)) begin
            s = s - (IDX_W+1)'(CAPACITY);
        end
        return s[IDX_W-1:0];
    endfunction

    // Control state
    logic [2:0]         r_state,    n_state;
    logic [IDX_W-1:0]   r_phead,    n_phead;
    logic [IDX_W-1:0]   r_ohead,    n_ohead;
    logic [CNT_W-1:0]   r_pcnt,     n_pcnt;
    logic [CNT_W-1:0]   r_ocnt,     n_ocnt;
    logic [IDX_W-1:0]   r_k,        n_k;
    logic               r_scls,     n_scls;
    logic               r_issue,    n_issue;
    logic               r_rd_vld,   n_rd_vld;
    logic               r_rd_cls,   n_rd_cls;
    logic               r_hit,      n_hit;
    logic               r_hit_cls,  n_hit_cls;
    logic               r_m_tvalid, n_m_tvalid;

    // Payload held for the item at work and for the output
    t_cmd               r_cmd,      n_cmd;
    logic [ID_BITS-1:0] r_id,       n_id;
    logic               r_pref,     n_pref;
    t_status            r_status,   n_status;
    logic [ID_BITS-1:0] r_served,   n_served;
    logic               r_cls,      n_cls;
    t_status            r_m_status, n_m_status;
    logic [ID_BITS-1:0] r_m_served, n_m_served;
    logic               r_m_cls,    n_m_cls;
    logic [CNT_W-1:0]   r_m_occ,    n_m_occ;

    // Entry memory: upper address bit set for the preferred class
    logic [ID_BITS-1:0] r_mem [2**ADDR_W];
    logic [ID_BITS-1:0] r_rd_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;

    logic [CNT_W-1:0]   w_total;
    logic [CNT_W-1:0]   w_scnt;
    logic [IDX_W-1:0]   w_shead;
    logic [CNT_W-1:0]   w_k_next;
    logic               w_hit_now;
    logic               w_scan_end;
    logic               w_accept;
    logic               w_load_out;

    assign w_total    = r_pcnt + r_ocnt;
    assign w_scnt     = r_scls ? r_pcnt : r_ocnt;
    assign w_shead    = r_scls ? r_phead : r_ohead;
    assign w_k_next   = CNT_W'(r_k) + CNT_W'(1);
    // The compare unit: one stored id against the item's id per cycle
    assign w_hit_now  = r_rd_vld && (r_rd_data == r_id);
    assign w_scan_end = w_hit_now || (!r_issue && !r_rd_vld);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_load_out = (r_state == S_DONE) && (!r_m_tvalid || i_m_tready);

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_phead    = r_phead;
        n_ohead    = r_ohead;
        n_pcnt     = r_pcnt;
        n_ocnt     = r_ocnt;
        n_k        = r_k;
        n_scls     = r_scls;
        n_issue    = r_issue;
        n_rd_vld   = 1'b0;
        n_rd_cls   = r_scls;
        n_hit      = r_hit;
        n_hit_cls  = r_hit_cls;
        n_cmd      = r_cmd;
        n_id       = r_id;
        n_pref     = r_pref;
        n_status   = r_status;
        n_served   = r_served;
        n_cls      = r_cls;
        n_m_tvalid = r_m_tvalid;
        n_m_status = r_m_status;
        n_m_served = r_m_served;
        n_m_cls    = r_m_cls;
        n_m_occ    = r_m_occ;
        rd_en      = 1'b0;
        rd_addr    = {r_scls, wrap_add(w_shead, r_k)};
        wr_en      = 1'b0;
        wr_addr    = {r_pref, r_pref ? wrap_add(r_phead, r_pcnt[IDX_W-1:0])
                                     : wrap_add(r_ohead, r_ocnt[IDX_W-1:0])};

        // Drop the output item once taken
        if (r_m_tvalid && i_m_tready) begin
            n_m_tvalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd     = i_s_tuser;
                    n_id      = i_s_tdata[ID_BITS-1:0];
                    n_pref    = i_s_tdata[ID_BITS];
                    n_status  = ST_DONE;
                    n_served  = '0;
                    n_cls     = 1'b0;
                    n_hit     = 1'b0;
                    n_hit_cls = 1'b0;
                    n_k       = '0;
                    case (i_s_tuser)
                        CMD_INSERT, CMD_LOOKUP: begin
                            // Walk the preferred class first, then ordinary
                            n_scls  = (r_pcnt != '0);
                            n_issue = (r_pcnt != '0) || (r_ocnt != '0);
                            n_state = S_SCAN;
                        end
                        CMD_SERVE: begin
                            if (r_pcnt != '0) begin
                                n_cls   = 1'b1;
                                n_state = S_FETCH;
                            end else if (r_ocnt != '0) begin
                                n_cls   = 1'b0;
                                n_state = S_FETCH;
                            end else begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                rd_en    = r_issue;
                n_rd_vld = r_issue && !w_scan_end;
                if (r_issue) begin
                    if (w_k_next == w_scnt) begin
                        if (r_scls && (r_ocnt != '0)) begin
                            n_scls = 1'b0;
                            n_k    = '0;
                        end else begin
                            n_issue = 1'b0;
                        end
                    end else begin
                        n_k = w_k_next[IDX_W-1:0];
                    end
                end
                if (w_scan_end) begin
                    n_issue   = 1'b0;
                    n_hit     = w_hit_now;
                    n_hit_cls = r_rd_cls;
                    n_state   = S_RESOLVE;
                end
            end

            S_RESOLVE: begin
                if (r_cmd == CMD_INSERT) begin
                    if (r_hit) begin
                        n_status = ST_DUP;
                    end else if (w_total >= CNT_W'(CAPACITY)) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_en = 1'b1;
                        if (r_pref) begin
                            n_pcnt = r_pcnt + CNT_W'(1);
                        end else begin
                            n_ocnt = r_ocnt + CNT_W'(1);
                        end
                    end
                end else begin
                    if (r_hit) begin
                        n_cls = r_hit_cls;
                    end else begin
                        n_status = ST_NOTFOUND;
                    end
                end
                n_state = S_DONE;
            end

            S_FETCH: begin
                // Read the front entry of the chosen class
                rd_en   = 1'b1;
                rd_addr = {r_cls, r_cls ? r_phead : r_ohead};
                n_state = S_TAKE;
            end

            S_TAKE: begin
                n_served = r_rd_data;
                if (r_cls) begin
                    n_phead = wrap_add(r_phead, IDX_W'(1));
                    n_pcnt  = r_pcnt - CNT_W'(1);
                end else begin
                    n_ohead = wrap_add(r_ohead, IDX_W'(1));
                    n_ocnt  = r_ocnt - CNT_W'(1);
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                // Advance once the output register is free
                if (w_load_out) begin
                    n_m_tvalid = 1'b1;
                    n_m_status = r_status;
                    n_m_served = r_served;
                    n_m_cls    = r_cls;
                    n_m_occ    = w_total;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phead    <= '0;
            r_ohead    <= '0;
            r_pcnt     <= '0;
            r_ocnt     <= '0;
            r_k        <= '0;
            r_scls     <= 1'b0;
            r_issue    <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_rd_cls   <= 1'b0;
            r_hit      <= 1'b0;
            r_hit_cls  <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phead    <= n_phead;
            r_ohead    <= n_ohead;
            r_pcnt     <= n_pcnt;
            r_ocnt     <= n_ocnt;
            r_k        <= n_k;
            r_scls     <= n_scls;
            r_issue    <= n_issue;
            r_rd_vld   <= n_rd_vld;
            r_rd_cls   <= n_rd_cls;
            r_hit      <= n_hit;
            r_hit_cls  <= n_hit_cls;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_id       <= n_id;
        r_pref     <= n_pref;
        r_status   <= n_status;
        r_served   <= n_served;
        r_cls      <= n_cls;
        r_m_status <= n_m_status;
        r_m_served <= n_m_served;
        r_m_cls    <= n_m_cls;
        r_m_occ    <= n_m_occ;
    end

    // Entry memory with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_id;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tuser  = r_m_status;
    generate
        if (PAD_W > 0) begin : g_pad
            assign o_m_tdata = {{PAD_W{1'b0}}, r_m_occ, r_m_cls, r_m_served};
        end else begin : g_nopad
            assign o_m_tdata = {r_m_occ, r_m_cls, r_m_served};
        end
    endgenerate

endmodule

`default_nettype wire

>>> sv/tcpq_checker.sv
// ----------------------------------------------------------------------------
// Two-class priority queue port checker
// Watches the queue's ports and flags results that cannot be right.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_class_priority_queue_defines.svh"

module tcpq_checker #(
    parameter int CAPACITY = 16,
    parameter int ID_BITS  = 16
) (
    input  wire logic                                                i_clk,
    input  wire logic                                                i_rst_n,
    input  wire logic                                                i_s_tvalid,
    input  wire logic                                                o_s_tready,
    input  wire logic [((ID_BITS+1+$clog2(CAPACITY+1)+7)/8)*8-1:0]   o_m_tdata,
    input  wire tcpq_pkg::t_status                                   o_m_tuser,
    input  wire logic                                                o_m_tvalid,
    input  wire logic                                                i_m_tready
);
    import tcpq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY+1);

    logic [ID_BITS-1:0] m_served;
    logic               m_cls;
    logic [CNT_W-1:0]   m_occ;

    assign m_served = o_m_tdata[ID_BITS-1:0];
    assign m_cls    = o_m_tdata[ID_BITS];
    assign m_occ    = o_m_tdata[ID_BITS+1 +: CNT_W];

    // A taken item keeps the input closed for at least the next cycle
    `TCPQ_ASSERT_NEXT(a_busy_after_accept, i_s_tvalid && o_s_tready, !o_s_tready, "ready after accept")

    // A stalled result holds
    `TCPQ_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "result changed under stall")

    // Empty and full results carry no entry and a consistent occupancy
    `TCPQ_ASSERT_NOW(a_empty, o_m_tvalid && (o_m_tuser == ST_EMPTY), (m_occ == '0) && (m_served == '0) && !m_cls, "bad empty result")

    `TCPQ_ASSERT_NOW(a_full, o_m_tvalid && (o_m_tuser == ST_FULL), (m_occ == CNT_W'(CAPACITY)) && (m_served == '0) && !m_cls, "bad full result")

    `TCPQ_ASSERT_NOW(a_occ_range, o_m_tvalid, m_occ <= CNT_W'(CAPACITY), "occupancy above capacity")

endmodule

bind two_class_priority_queue tcpq_checker #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS)
) u_tcpq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);

`default_nettype wire
